FILE: rtl/ckgb_pkg.sv
package ckgb_pkg;

	localparam int FA_W  = 13;
	localparam int FB_W  = 17;
	localparam int RGB_W = 24;
	localparam int CNT_W = 3;

	localparam logic [1:0] REQ_LOAD_PIXEL = 2'd0;
	localparam logic [1:0] REQ_LOAD_GLYPH = 2'd1;
	localparam logic [1:0] REQ_DRAW       = 2'd2;

	localparam logic [1:0] REG_FONT_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FONT_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COLOR_KEY   = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [FA_W-1:0]   font_addr;
		logic [RGB_W-1:0]  pixel_color;
		logic [7:0]        glyph_code;
		logic [9:0]        glyph_column;
		logic [3:0]        glyph_width;
		logic signed [7:0] adjust_x;
		logic signed [7:0] adjust_y;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
	} req_t;

	typedef struct packed {
		logic [FB_W-1:0]  fb_addr;
		logic [RGB_W-1:0] fb_color;
		logic             write_enable;
		logic             is_last;
	} res_t;

	typedef struct packed {
		logic [1:0]       index;
		logic [RGB_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic [9:0]        column;
		logic [3:0]        width;
		logic signed [7:0] adjust_x;
		logic signed [7:0] adjust_y;
	} glyph_t;

endpackage

FILE: rtl/ckgb_intf.sv
interface ckgb_req_if;
	logic          valid;
	logic          ready;
	ckgb_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ckgb_res_if;
	logic          valid;
	logic          ready;
	ckgb_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ckgb_cfg_if;
	logic          valid;
	logic          ready;
	ckgb_pkg::cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/color_keyed_glyph_blitter.sv
// Glyph blitter: font pixel loads and glyph entry loads give no result. A draw reads the glyph
// table in its accept cycle, then steps through the setup states LOOK (position add), CLIP
// (left/top clip), TRIM (right/bottom trim) and INIT (row base multiply), and then walks one
// visible glyph pixel per cycle, up to 64, unless a stalled result side holds the walk, since
// the single read port of the font store serves one pixel a cycle; a draw clipped to nothing
// returns to idle from CLIP or TRIM. A new request is taken only after the last pixel is issued.
// Results come bottom row first, right to left; the last screen column and row are
// never drawn. Font store and glyph table are not cleared at reset and must be written before use.
module color_keyed_glyph_blitter #(
	parameter int SCREEN_W    = 320,
	parameter int SCREEN_H    = 240,
	parameter int FONT_H_MAX  = 8,
	parameter int GLYPH_W_MAX = 8
) (
	input logic         clk,
	input logic         arst_n,
	ckgb_cfg_if.sink    cfg,
	ckgb_req_if.sink    req,
	ckgb_res_if.source  res
);

	localparam int XW = $clog2(SCREEN_W);
	localparam int YW = $clog2(SCREEN_H);
	localparam int FA_W = ckgb_pkg::FA_W;
	localparam int FB_W = ckgb_pkg::FB_W;
	localparam int RGB_W = ckgb_pkg::RGB_W;
	localparam int CNT_W = ckgb_pkg::CNT_W;
	localparam logic signed [14:0] XLIM = 15'(SCREEN_W);
	localparam logic signed [14:0] YLIM = 15'(SCREEN_H);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_CLIP = 3'd2;
	localparam logic [2:0] ST_TRIM = 3'd3;
	localparam logic [2:0] ST_INIT = 3'd4;
	localparam logic [2:0] ST_WALK = 3'd5;

	logic [RGB_W-1:0]      font_mem [2**FA_W];
	ckgb_pkg::glyph_t      glyph_mem [256];

	logic [2:0]            state_q;
	logic [10:0]           font_width_q;
	logic [3:0]            font_height_q;
	logic [RGB_W-1:0]      color_key_q;

	logic signed [11:0]    pos_x_q, pos_y_q;
	ckgb_pkg::glyph_t      glyph_rd_q;
	logic [RGB_W-1:0]      font_rd_q;

	logic signed [14:0]    sx_q, sy_q;
	logic [9:0]            col_q;
	logic [3:0]            gw_q, gh_q;

	logic [XW-1:0]         sx2_q;
	logic [YW-1:0]         sy2_q;
	logic [3:0]            gw2_q, gh2_q;
	logic [FA_W-1:0]       gx2_q;
	logic [CNT_W-1:0]      gy2_q;

	logic [3:0]            gw3_q, gh3_q;

	logic [CNT_W-1:0]      r_q, c_q, cmax_q;
	logic [FA_W-1:0]       font_row_q;
	logic [FB_W-1:0]       fb_row_q;

	logic                  s1_valid_q;
	logic [FB_W-1:0]       fb_s1;
	logic                  last_s1;
	logic                  out_valid_q;
	ckgb_pkg::res_t        out_q;

	logic                  acc, adv, issue, last_now;
	logic [3:0]            w_clamp, h_clamp;
	logic signed [14:0]    gwl, ghl, nsy;
	logic                  clip_empty;
	logic [XW:0]           sum_x;
	logic [YW:0]           sum_y;
	logic [3:0]            gw_t, gh_t;
	logic [CNT_W-1:0]      frow;
	logic [YW:0]           srow;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign adv       = !out_valid_q || res.ready;
	assign issue     = (state_q == ST_WALK) && adv;
	assign last_now  = (r_q == '0) && (c_q == '0);

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	assign w_clamp = (req.data.glyph_width > 4'(GLYPH_W_MAX)) ? 4'(GLYPH_W_MAX)
		: req.data.glyph_width;
	assign h_clamp = (font_height_q > 4'(FONT_H_MAX)) ? 4'(FONT_H_MAX) : font_height_q;

	// left and top clip
	assign gwl = $signed({11'd0, gw_q}) + sx_q;
	assign ghl = $signed({11'd0, gh_q}) + sy_q;
	assign nsy = -sy_q;
	assign clip_empty = (sx_q >= XLIM) || (sy_q >= YLIM)
		|| gwl[14] || (gwl == '0) || ghl[14] || (ghl == '0);

	// right and bottom trim
	assign sum_x = {1'b0, sx2_q} + (XW+1)'(gw2_q);
	assign sum_y = {1'b0, sy2_q} + (YW+1)'(gh2_q);
	assign gw_t  = (sum_x >= (XW+1)'(SCREEN_W)) ? 4'(XW'(SCREEN_W - 1) - sx2_q) : gw2_q;
	assign gh_t  = (sum_y >= (YW+1)'(SCREEN_H)) ? 4'(YW'(SCREEN_H - 1) - sy2_q) : gh2_q;

	// bottom row of the visible part
	assign frow = CNT_W'({1'b0, gy2_q} + gh3_q - 4'd1);
	assign srow = (YW+1)'({1'b0, sy2_q} + (YW+1)'(gh3_q) - (YW+1)'(1));

	always_ff @(posedge clk) begin
		if (acc && req.data.req_type == ckgb_pkg::REQ_LOAD_PIXEL) begin
			font_mem[req.data.font_addr] <= req.data.pixel_color;
		end
		if (issue) begin
			font_rd_q <= font_mem[font_row_q + FA_W'(c_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (acc && req.data.req_type == ckgb_pkg::REQ_LOAD_GLYPH) begin
			glyph_mem[req.data.glyph_code] <= '{column: req.data.glyph_column,
				width: w_clamp, adjust_x: req.data.adjust_x, adjust_y: req.data.adjust_y};
		end
		if (acc && req.data.req_type == ckgb_pkg::REQ_DRAW) begin
			glyph_rd_q <= glyph_mem[req.data.glyph_code];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_width_q  <= 11'd1024;
			font_height_q <= 4'd8;
			color_key_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				ckgb_pkg::REG_FONT_WIDTH:  font_width_q  <= cfg.data.value[10:0];
				ckgb_pkg::REG_FONT_HEIGHT: font_height_q <= cfg.data.value[3:0];
				ckgb_pkg::REG_COLOR_KEY:   color_key_q   <= cfg.data.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc && req.data.req_type == ckgb_pkg::REQ_DRAW) state_q <= ST_LOOK;
				end
				ST_LOOK: state_q <= ST_CLIP;
				ST_CLIP: state_q <= clip_empty ? ST_IDLE : ST_TRIM;
				ST_TRIM: state_q <= (gw_t == '0 || gh_t == '0) ? ST_IDLE : ST_INIT;
				ST_INIT: state_q <= ST_WALK;
				ST_WALK: begin
					if (issue && last_now) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_x_q <= req.data.pos_x;
			pos_y_q <= req.data.pos_y;
		end
		if (state_q == ST_LOOK) begin
			sx_q  <= {{3{pos_x_q[11]}}, pos_x_q} + {{7{glyph_rd_q.adjust_x[7]}},
				glyph_rd_q.adjust_x};
			sy_q  <= {{3{pos_y_q[11]}}, pos_y_q} + {{7{glyph_rd_q.adjust_y[7]}},
				glyph_rd_q.adjust_y};
			col_q <= glyph_rd_q.column;
			gw_q  <= glyph_rd_q.width;
			gh_q  <= h_clamp;
		end
		if (state_q == ST_CLIP) begin
			sx2_q <= sx_q[14] ? '0 : sx_q[XW-1:0];
			sy2_q <= sy_q[14] ? '0 : sy_q[YW-1:0];
			gw2_q <= sx_q[14] ? gwl[3:0] : gw_q;
			gh2_q <= sy_q[14] ? ghl[3:0] : gh_q;
			gx2_q <= FA_W'(col_q) - (sx_q[14] ? sx_q[FA_W-1:0] : '0);
			gy2_q <= sy_q[14] ? nsy[CNT_W-1:0] : '0;
		end
		if (state_q == ST_TRIM) begin
			gw3_q <= gw_t;
			gh3_q <= gh_t;
		end
		if (state_q == ST_INIT) begin
			r_q        <= CNT_W'(gh3_q - 4'd1);
			c_q        <= CNT_W'(gw3_q - 4'd1);
			cmax_q     <= CNT_W'(gw3_q - 4'd1);
			font_row_q <= FA_W'(FA_W'(frow) * FA_W'(font_width_q)) + gx2_q;
			fb_row_q   <= FB_W'(FB_W'(srow) * FB_W'(SCREEN_W)) + FB_W'(sx2_q);
		end else if (issue) begin
			fb_s1   <= fb_row_q + FB_W'(c_q);
			last_s1 <= last_now;
			if (c_q == '0) begin
				r_q        <= r_q - CNT_W'(1);
				c_q        <= cmax_q;
				font_row_q <= font_row_q - FA_W'(font_width_q);
				fb_row_q   <= fb_row_q - FB_W'(SCREEN_W);
			end else begin
				c_q <= c_q - CNT_W'(1);
			end
		end
		if (adv && s1_valid_q) begin
			out_q.fb_addr      <= fb_s1;
			out_q.fb_color     <= font_rd_q;
			out_q.write_enable <= (font_rd_q != color_key_q);
			out_q.is_last      <= last_s1;
		end
	end

	// hold the read stage and the output beat while the result side stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q  <= issue;
			out_valid_q <= s1_valid_q;
		end
	end

endmodule
